@@ rtl/u8d_pkg.sv @@
`default_nettype none

package u8d_pkg;

    localparam int OFFSET_WIDTH = 32;
    localparam int CP_W         = 21;
    localparam int OUT_OFF_W    = 32;
    localparam int TDATA_W      = 56;
    localparam int TUSER_W      = 2;

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    typedef struct packed {
        logic [7:0]              lead;
        logic [1:0]              exp;
        logic [1:0]              seen;
        logic [CP_W-1:0]         part;
        logic [OFFSET_WIDTH-1:0] start;
        logic [OFFSET_WIDTH-1:0] pos;
    } t_state;

    // results of one byte: a run of replacements, then an optional tail result
    typedef struct packed {
        logic [1:0]              run;
        logic [OFFSET_WIDTH-1:0] run_off;
        logic                    tail_v;
        logic [CP_W-1:0]         tail_cp;
        logic [OFFSET_WIDTH-1:0] tail_off;
        logic                    tail_rep;
        logic                    fin;
    } t_job;

endpackage

`default_nettype wire

@@ rtl/u8d_dec.sv @@
`default_nettype none

module u8d_dec (
    input  var u8d_pkg::t_state i_st,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_end,
    output u8d_pkg::t_state     o_st,
    output u8d_pkg::t_job       o_job
);

    always_comb begin
        logic                     pend;
        logic                     ok;
        logic [7:0]               lo;
        logic [7:0]               hi;
        logic [2:0]               seen_inc;
        logic [26:0]              shifted;
        logic                     lascii;
        logic [1:0]               lexp;
        logic [u8d_pkg::CP_W-1:0] lpart;
        u8d_pkg::t_state          s;
        u8d_pkg::t_job            j;

        pend     = (i_st.exp != 2'd0);
        seen_inc = {1'b0, i_st.seen} + 3'd1;
        shifted  = {i_st.part, i_byte[5:0]};

        lo = 8'h80;
        hi = 8'hBF;
        if (i_st.seen == 2'd0) begin
            if (i_st.lead == 8'hE0) begin
                lo = 8'hA0;
            end else if (i_st.lead == 8'hED) begin
                hi = 8'h9F;
            end else if (i_st.lead == 8'hF0) begin
                lo = 8'h90;
            end else if (i_st.lead == 8'hF4) begin
                hi = 8'h8F;
            end
        end
        ok = (i_byte >= lo) && (i_byte <= hi);

        lascii = (i_byte < 8'h80);
        lexp   = 2'd0;
        lpart  = '0;
        if (i_byte >= 8'hC2 && i_byte <= 8'hDF) begin
            lexp  = 2'd1;
            lpart = u8d_pkg::CP_W'(i_byte[4:0]);
        end else if (i_byte[7:4] == 4'hE) begin
            lexp  = 2'd2;
            lpart = u8d_pkg::CP_W'(i_byte[3:0]);
        end else if (i_byte >= 8'hF0 && i_byte <= 8'hF4) begin
            lexp  = 2'd3;
            lpart = u8d_pkg::CP_W'(i_byte[2:0]);
        end

        s          = i_st;
        j          = '0;
        j.fin      = i_end;
        j.run_off  = i_st.start;
        j.tail_cp  = u8d_pkg::REPL_CP;
        j.tail_off = i_st.pos;

        if (pend && ok) begin
            s.part = shifted[u8d_pkg::CP_W-1:0];
            s.seen = seen_inc[1:0];
            if (seen_inc[1:0] == i_st.exp) begin
                j.tail_v   = 1'b1;
                j.tail_cp  = shifted[u8d_pkg::CP_W-1:0];
                j.tail_off = i_st.start;
                j.tail_rep = 1'b0;
                s.lead     = '0;
                s.exp      = '0;
                s.seen     = '0;
                s.part     = '0;
            end
        end else begin
            if (pend) begin
                j.run  = seen_inc[1:0];
                s.lead = '0;
                s.exp  = '0;
                s.seen = '0;
                s.part = '0;
            end
            priority if (lascii) begin
                j.tail_v   = 1'b1;
                j.tail_cp  = u8d_pkg::CP_W'(i_byte);
                j.tail_rep = 1'b0;
            end else if (lexp != 2'd0) begin
                s.exp   = lexp;
                s.part  = lpart;
                s.lead  = i_byte;
                s.seen  = 2'd0;
                s.start = i_st.pos;
            end else begin
                j.tail_v   = 1'b1;
                j.tail_rep = 1'b1;
            end
        end

        // truncated sequence at text end
        if (i_end && s.exp != 2'd0) begin
            if (pend && ok) begin
                j.run     = s.seen + 2'd1;
                j.run_off = s.start;
            end else begin
                j.tail_v   = 1'b1;
                j.tail_off = s.start;
                j.tail_rep = 1'b1;
            end
            s.lead = '0;
            s.exp  = '0;
            s.seen = '0;
            s.part = '0;
        end

        s.pos = i_end ? '0 : i_st.pos + u8d_pkg::OFFSET_WIDTH'(1);

        o_st  = s;
        o_job = j;
    end

endmodule

`default_nettype wire

@@ rtl/utf8_decoder_with_replacement_core.sv @@
`default_nettype none

// Channel   Dir  Beat content
// s_axis    in   tdata[7:0] data_byte, tlast text_end
// m_axis    out  tdata[20:0] code_point, tdata[52:21] byte_offset, tdata[55:53] zero,
//                tlast run_last, tuser[0] replaced, tuser[1] final_result
//
// One byte per cycle unless stalled: input register, one decode pass, result register.
// A byte with k results holds the input side until its last result is taken (k up to 4,
// extra results only on invalid or truncated sequences).
// Output stalls back up into the input register only when the result register is busy.
// Synchronous active-low reset clears decoder state and the byte offset.

module utf8_decoder_with_replacement_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [7:0]                     i_s_axis_tdata,  // [7:0] data_byte
    input  wire logic                           i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic [u8d_pkg::TDATA_W-1:0]         o_m_axis_tdata,  // code_point, byte_offset
    output logic                                o_m_axis_tlast,
    output logic [u8d_pkg::TUSER_W-1:0]         o_m_axis_tuser   // replaced, final_result
);

    logic                               r_in_v;
    logic [7:0]                         r_in_byte;
    logic                               r_in_last;
    u8d_pkg::t_state                    r_st;
    u8d_pkg::t_state                    n_st;
    u8d_pkg::t_job                      w_job;

    logic                               r_ov;
    logic                               n_ov;
    logic [1:0]                         r_run_left;
    logic [1:0]                         n_run_left;
    logic                               r_tail_v;
    logic                               n_tail_v;
    logic [u8d_pkg::CP_W-1:0]           r_cp;
    logic [u8d_pkg::CP_W-1:0]           n_cp;
    logic [u8d_pkg::OFFSET_WIDTH-1:0]   r_off;
    logic [u8d_pkg::OFFSET_WIDTH-1:0]   n_off;
    logic                               r_rep;
    logic                               n_rep;
    logic [u8d_pkg::CP_W-1:0]           r_tail_cp;
    logic [u8d_pkg::CP_W-1:0]           n_tail_cp;
    logic [u8d_pkg::OFFSET_WIDTH-1:0]   r_tail_off;
    logic [u8d_pkg::OFFSET_WIDTH-1:0]   n_tail_off;
    logic                               r_tail_rep;
    logic                               n_tail_rep;
    logic                               r_end;
    logic                               n_end;

    logic                               w_take;
    logic                               w_cur_last;
    logic                               w_free;
    logic                               w_has;
    logic                               w_consume;

    u8d_dec u_dec (
        .i_st   (r_st),
        .i_byte (r_in_byte),
        .i_end  (r_in_last),
        .o_st   (n_st),
        .o_job  (w_job)
    );

    assign w_take     = r_ov && i_m_axis_tready;
    assign w_cur_last = (r_run_left == 2'd0) && !r_tail_v;
    assign w_free     = !r_ov || (w_take && w_cur_last);
    assign w_has      = (w_job.run != 2'd0) || w_job.tail_v;
    assign w_consume  = r_in_v && (w_free || !w_has);

    assign o_s_axis_tready = !r_in_v || w_consume;

    always_comb begin
        n_ov       = r_ov;
        n_run_left = r_run_left;
        n_tail_v   = r_tail_v;
        n_cp       = r_cp;
        n_off      = r_off;
        n_rep      = r_rep;
        n_tail_cp  = r_tail_cp;
        n_tail_off = r_tail_off;
        n_tail_rep = r_tail_rep;
        n_end      = r_end;

        if (w_take) begin
            if (w_cur_last) begin
                n_ov = 1'b0;
            end else if (r_run_left != 2'd0) begin
                n_off      = r_off + u8d_pkg::OFFSET_WIDTH'(1);
                n_run_left = r_run_left - 2'd1;
            end else begin
                n_cp     = r_tail_cp;
                n_off    = r_tail_off;
                n_rep    = r_tail_rep;
                n_tail_v = 1'b0;
            end
        end

        if (w_consume && w_has) begin
            n_ov       = 1'b1;
            n_end      = w_job.fin;
            n_tail_cp  = w_job.tail_cp;
            n_tail_off = w_job.tail_off;
            n_tail_rep = w_job.tail_rep;
            if (w_job.run != 2'd0) begin
                n_cp       = u8d_pkg::REPL_CP;
                n_off      = w_job.run_off;
                n_rep      = 1'b1;
                n_run_left = w_job.run - 2'd1;
                n_tail_v   = w_job.tail_v;
            end else begin
                n_cp       = w_job.tail_cp;
                n_off      = w_job.tail_off;
                n_rep      = w_job.tail_rep;
                n_run_left = 2'd0;
                n_tail_v   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v     <= 1'b0;
            r_st       <= '0;
            r_ov       <= 1'b0;
            r_run_left <= 2'd0;
            r_tail_v   <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_v <= i_s_axis_tvalid;
            end
            if (w_consume) begin
                r_st <= n_st;
            end
            r_ov       <= n_ov;
            r_run_left <= n_run_left;
            r_tail_v   <= n_tail_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        r_cp       <= n_cp;
        r_off      <= n_off;
        r_rep      <= n_rep;
        r_tail_cp  <= n_tail_cp;
        r_tail_off <= n_tail_off;
        r_tail_rep <= n_tail_rep;
        r_end      <= n_end;
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {3'b000, u8d_pkg::OUT_OFF_W'(r_off), r_cp};
    assign o_m_axis_tlast  = w_cur_last;
    assign o_m_axis_tuser  = {w_cur_last && r_end, r_rep};

    a_run_is_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_run_left != 2'd0) |-> (r_rep && r_cp == u8d_pkg::REPL_CP))
        else $error("replacement run carries a non-replacement result");

    a_seen_below_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.exp != 2'd0) |-> (r_st.seen < r_st.exp))
        else $error("pending sequence already complete");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.exp == 2'd0) |-> (r_st.seen == 2'd0 && r_st.lead == 8'h00))
        else $error("stale pending state with no sequence open");

    a_end_resets_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_in_last) |=> (r_st.pos == '0 && r_st.exp == 2'd0))
        else $error("text end did not restart offset or flush sequence");

    a_end_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && r_in_last) |-> w_has)
        else $error("text end byte gave no result");

endmodule

`default_nettype wire
